[rtl/tmpra_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmpra_pkg
// Shared types, codes and the microcode table of the temp register allocator.
// ----------------------------------------------------------------------------
package tmpra_pkg;

	// Operation selector carried on the input beat.
	localparam logic [1:0] MODE_ACQUIRE = 2'd0;
	localparam logic [1:0] MODE_RELEASE = 2'd1;
	localparam logic [1:0] MODE_QUERY   = 2'd2;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_NO_SPILL  = 2'd1;
	localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;
	localparam logic [1:0] STATUS_OVERFLOW  = 2'd3;

	localparam logic [1:0] MOVE_NONE   = 2'd0;
	localparam logic [1:0] MOVE_SPILL  = 2'd1;
	localparam logic [1:0] MOVE_RELOAD = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_ACTIVE_SLOTS = 2'd0;
	localparam logic [1:0] CFG_REG_MAP      = 2'd1;
	localparam logic [1:0] CFG_SPILL_ENABLE = 2'd2;
	localparam logic [1:0] CFG_STACK_REG    = 2'd3;

	localparam int REG_BITS     = 8;
	localparam int MAP_SLOTS    = 8;
	localparam int OFFSET_BITS  = 16;
	localparam int WORD_SHIFT   = 2;
	localparam int INUSE_BITS   = 12;
	localparam int INUSE_MAX    = 4095;

	// Result beat layout, lowest bit first.
	localparam int OUT_STATUS_LSB = 0;
	localparam int OUT_PHYS_LSB   = 2;
	localparam int OUT_KIND_LSB   = 10;
	localparam int OUT_OFF_LSB    = 12;
	localparam int OUT_BASE_LSB   = 28;
	localparam int OUT_HELD_LSB   = 36;
	localparam int OUT_INUSE_LSB  = 37;
	localparam int OUT_PEAK_LSB   = 49;
	localparam int OUT_POOL_LSB   = 61;
	localparam int OUT_DATA_BITS  = 64;

	typedef enum logic [2:0] {
		OP_IDLE   = 3'd0,
		OP_LOAD   = 3'd1,
		OP_DECIDE = 3'd2,
		OP_OFFSET = 3'd3,
		OP_LOADF  = 3'd4,
		OP_MULF   = 3'd5,
		OP_FINISH = 3'd6
	} op_t;

	typedef enum logic [1:0] {
		JC_NONE     = 2'd0,
		JC_WAIT_IN  = 2'd1,
		JC_NO_MOVE  = 2'd2,
		JC_OUT_BUSY = 2'd3
	} jcond_t;

	localparam int STEP_W = 3;
	typedef logic [STEP_W-1:0] step_t;

	localparam step_t ST_IDLE   = 3'd0;
	localparam step_t ST_LOAD   = 3'd1;
	localparam step_t ST_DECIDE = 3'd2;
	localparam step_t ST_OFFSET = 3'd3;
	localparam step_t ST_LOADF  = 3'd4;
	localparam step_t ST_MULF   = 3'd5;
	localparam step_t ST_FINISH = 3'd6;

	typedef struct packed {
		op_t    op;
		jcond_t jc;
		step_t  target;
		logic   ret;
	} uword_t;

	// Status seen by the sequencer when it picks the next step.
	typedef struct packed {
		logic in_valid;
		logic no_move;
		logic out_busy;
	} seq_cond_t;

	function automatic uword_t ucode(input step_t step);
		uword_t w;
		w = '{op: OP_IDLE, jc: JC_NONE, target: ST_IDLE, ret: 1'b1};
		case (step)
			ST_IDLE:   w = '{op: OP_IDLE,   jc: JC_WAIT_IN,  target: ST_IDLE,   ret: 1'b0};
			ST_LOAD:   w = '{op: OP_LOAD,   jc: JC_NONE,     target: ST_IDLE,   ret: 1'b0};
			ST_DECIDE: w = '{op: OP_DECIDE, jc: JC_NO_MOVE,  target: ST_LOADF,  ret: 1'b0};
			ST_OFFSET: w = '{op: OP_OFFSET, jc: JC_NONE,     target: ST_IDLE,   ret: 1'b0};
			ST_LOADF:  w = '{op: OP_LOADF,  jc: JC_NONE,     target: ST_IDLE,   ret: 1'b0};
			ST_MULF:   w = '{op: OP_MULF,   jc: JC_NONE,     target: ST_IDLE,   ret: 1'b0};
			ST_FINISH: w = '{op: OP_FINISH, jc: JC_OUT_BUSY, target: ST_FINISH, ret: 1'b1};
			default:   w = '{op: OP_IDLE,   jc: JC_NONE,     target: ST_IDLE,   ret: 1'b1};
		endcase
		return w;
	endfunction

endpackage

[rtl/tmpra_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmpra_seq
// Step counter and microcode table that drive the allocator datapath.
// ----------------------------------------------------------------------------
module tmpra_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  tmpra_pkg::seq_cond_t cond,
	output tmpra_pkg::op_t      op
);
	import tmpra_pkg::*;

	step_t  step_q;
	uword_t word_c;
	logic   jump_c;

	always_comb begin
		word_c = ucode(step_q);
		case (word_c.jc)
			JC_NONE:     jump_c = 1'b0;
			JC_WAIT_IN:  jump_c = !cond.in_valid;
			JC_NO_MOVE:  jump_c = cond.no_move;
			JC_OUT_BUSY: jump_c = cond.out_busy;
			default:     jump_c = 1'b0;
		endcase
	end

	assign op = word_c.op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else if (jump_c) begin
			step_q <= word_c.target;
		end else if (word_c.ret) begin
			step_q <= ST_IDLE;
		end else begin
			step_q <= step_q + step_t'(1);
		end
	end

endmodule

[rtl/temp_register_spill_allocator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temp_register_spill_allocator_core
// Round-robin temp register allocator with spill and reload ordering.
// ----------------------------------------------------------------------------
// A taken beat runs through the load, decide, offset, load-final and multiply
// steps to the finish step, which registers the result; offset is skipped
// without a spill or reload. Items are worked one at a time; finish waits on
// a stalled result. One count read port and one multiplier are shared by steps.
// Reset: counts, peak and valid clear at once; config registers reset too.
// ----------------------------------------------------------------------------
module temp_register_spill_allocator_core #(
	parameter int NUM_SLOTS  = 8,
	parameter int COUNT_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // query_reg
	input  logic [1:0]  s_tuser,   // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	// status, phys_reg, move_kind, stack_offset, base_reg, still_held,
	// temps_in_use, peak_in_use, is_pool_reg, zero fill
	output logic [63:0] m_tdata,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import tmpra_pkg::*;

	localparam int IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int N_W    = $clog2(NUM_SLOTS + 1);
	localparam int PROD_W = COUNT_BITS + N_W;
	localparam int SUM_W  = PROD_W + 2;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	// Configuration registers.
	logic [3:0]             active_slots_q;
	logic [63:0]            reg_map_q;
	logic                   spill_enable_q;
	logic [REG_BITS-1:0]    stack_reg_q;

	logic [COUNT_BITS-1:0]  cnt_q [NUM_SLOTS];
	logic [INUSE_BITS-1:0]  peak_q;

	// Per-item working registers.
	logic [1:0]             mode_q;
	logic [REG_BITS-1:0]    qreg_q;
	logic [IDX_W-1:0]       idx_q;
	logic [COUNT_BITS-1:0]  cur_q;
	logic [COUNT_BITS-1:0]  cval_q;
	logic [PROD_W-1:0]      mul_q;
	logic [1:0]             status_q;
	logic [1:0]             kind_q;
	logic                   held_q;
	logic                   pool_q;
	logic                   upd_peak_q;
	logic [REG_BITS-1:0]    preg_q;
	logic [OFFSET_BITS-1:0] off_q;

	op_t       op;
	seq_cond_t cond;

	logic [N_W-1:0]         n_c;
	logic [REG_BITS-1:0]    regs_c [NUM_SLOTS];
	logic [IDX_W-1:0]       acq_c;
	logic [IDX_W-1:0]       rel_c;
	logic [IDX_W-1:0]       rd_idx_c;
	logic [COUNT_BITS-1:0]  rd_cnt_c;
	logic                   pool_c;

	logic [1:0]             dec_status_c;
	logic [1:0]             dec_kind_c;
	logic                   dec_held_c;
	logic                   dec_wr_c;
	logic                   dec_peak_c;
	logic [COUNT_BITS-1:0]  dec_cval_c;
	logic [COUNT_BITS-1:0]  dec_new_c;

	logic [SUM_W-1:0]       off_sum_c;
	logic [SUM_W-1:0]       inuse_sum_c;
	logic [INUSE_BITS-1:0]  inuse_c;
	logic [INUSE_BITS-1:0]  peak_next_c;
	logic                   out_busy_c;

	// Slot count limit, register per slot, and the two neighbor scans.
	always_comb begin
		if (active_slots_q == 4'd0) begin
			n_c = N_W'(1);
		end else if (32'(active_slots_q) > NUM_SLOTS) begin
			n_c = N_W'(NUM_SLOTS);
		end else begin
			n_c = N_W'(active_slots_q);
		end

		for (int i = 0; i < NUM_SLOTS; i++) begin
			regs_c[i] = (i < MAP_SLOTS) ? REG_BITS'(reg_map_q >> (REG_BITS * i)) : '0;
		end

		// Acquire takes the highest slot whose count is below its lower neighbor.
		acq_c = '0;
		for (int i = 1; i < NUM_SLOTS; i++) begin
			if (i < int'(n_c) && cnt_q[i] < cnt_q[i-1]) begin
				acq_c = IDX_W'(i);
			end
		end

		// Release takes the lowest slot whose count is above its upper neighbor.
		rel_c = IDX_W'(n_c - N_W'(1));
		for (int i = NUM_SLOTS - 2; i >= 0; i--) begin
			if (i + 1 < int'(n_c) && cnt_q[i] > cnt_q[i+1]) begin
				rel_c = IDX_W'(i);
			end
		end

		pool_c = 1'b0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (i < int'(n_c) && regs_c[i] == qreg_q) begin
				pool_c = 1'b1;
			end
		end
	end

	// Single count read port, shared by the chosen slot and the release slot.
	assign rd_idx_c = (op == OP_LOAD && mode_q == MODE_ACQUIRE) ? acq_c : rel_c;
	assign rd_cnt_c = cnt_q[rd_idx_c];

	always_comb begin
		dec_status_c = STATUS_OK;
		dec_kind_c   = MOVE_NONE;
		dec_held_c   = 1'b0;
		dec_wr_c     = 1'b0;
		dec_peak_c   = 1'b0;
		dec_cval_c   = cur_q;
		dec_new_c    = cur_q;
		case (mode_q)
			MODE_ACQUIRE: begin
				if (cur_q != '0 && !spill_enable_q) begin
					dec_status_c = STATUS_NO_SPILL;
				end else if (cur_q == COUNT_MAX) begin
					dec_status_c = STATUS_OVERFLOW;
				end else begin
					dec_kind_c = (cur_q != '0) ? MOVE_SPILL : MOVE_NONE;
					dec_new_c  = cur_q + COUNT_BITS'(1);
					dec_wr_c   = 1'b1;
					dec_peak_c = 1'b1;
				end
			end
			MODE_RELEASE: begin
				if (cur_q == '0) begin
					dec_status_c = STATUS_UNDERFLOW;
				end else begin
					dec_new_c  = cur_q - COUNT_BITS'(1);
					dec_cval_c = dec_new_c;
					dec_held_c = (dec_new_c != '0);
					dec_kind_c = dec_held_c ? MOVE_RELOAD : MOVE_NONE;
					dec_wr_c   = 1'b1;
				end
			end
			default: begin
				dec_status_c = STATUS_OK;
			end
		endcase
	end

	// Offset is 4*((c-1)*n + s + c); only the low bits survive.
	assign off_sum_c   = SUM_W'(mul_q) + SUM_W'(idx_q) + SUM_W'(cval_q);
	assign inuse_sum_c = SUM_W'(mul_q) + SUM_W'(idx_q) + SUM_W'(1);

	always_comb begin
		if (cur_q == '0) begin
			inuse_c = '0;
		end else if (32'(inuse_sum_c) > INUSE_MAX) begin
			inuse_c = INUSE_BITS'(INUSE_MAX);
		end else begin
			inuse_c = INUSE_BITS'(inuse_sum_c);
		end
		peak_next_c = (upd_peak_q && inuse_c > peak_q) ? inuse_c : peak_q;
	end

	assign out_busy_c    = m_tvalid && !m_tready;
	assign s_tready      = (op == OP_IDLE);
	assign cond.in_valid = s_tvalid;
	assign cond.no_move  = (dec_kind_c == MOVE_NONE);
	assign cond.out_busy = out_busy_c;

	tmpra_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cond   (cond),
		.op     (op)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_slots_q <= 4'd8;
			reg_map_q      <= '0;
			spill_enable_q <= 1'b1;
			stack_reg_q    <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_ACTIVE_SLOTS: active_slots_q <= cfg_data[3:0];
				CFG_REG_MAP:      reg_map_q      <= cfg_data;
				CFG_SPILL_ENABLE: spill_enable_q <= cfg_data[0];
				CFG_STACK_REG:    stack_reg_q    <= cfg_data[REG_BITS-1:0];
				default:          stack_reg_q    <= stack_reg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				cnt_q[i] <= '0;
			end
			peak_q   <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (op == OP_DECIDE && dec_wr_c) begin
				cnt_q[idx_q] <= dec_new_c;
			end
			if (op == OP_FINISH && !out_busy_c) begin
				peak_q   <= peak_next_c;
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_IDLE: begin
				if (s_tvalid) begin
					mode_q <= s_tuser;
					qreg_q <= s_tdata;
				end
			end
			OP_LOAD: begin
				idx_q <= rd_idx_c;
				cur_q <= rd_cnt_c;
			end
			OP_DECIDE: begin
				status_q   <= dec_status_c;
				kind_q     <= dec_kind_c;
				held_q     <= dec_held_c;
				upd_peak_q <= dec_peak_c;
				cval_q     <= dec_cval_c;
				pool_q     <= (mode_q == MODE_QUERY) && pool_c;
				preg_q     <= (mode_q == MODE_ACQUIRE || mode_q == MODE_RELEASE) ?
				              regs_c[idx_q] : '0;
				off_q      <= '0;
				mul_q      <= PROD_W'(dec_cval_c - COUNT_BITS'(1)) * PROD_W'(n_c);
			end
			OP_OFFSET: begin
				off_q <= OFFSET_BITS'(off_sum_c) << WORD_SHIFT;
			end
			OP_LOADF: begin
				idx_q <= rel_c;
				cur_q <= rd_cnt_c;
			end
			OP_MULF: begin
				mul_q <= PROD_W'(cur_q - COUNT_BITS'(1)) * PROD_W'(n_c);
			end
			OP_FINISH: begin
				if (!out_busy_c) begin
					m_tdata[OUT_DATA_BITS-1:OUT_POOL_LSB+1] <= '0;
					m_tdata[OUT_STATUS_LSB +: 2]          <= status_q;
					m_tdata[OUT_PHYS_LSB +: REG_BITS]     <= preg_q;
					m_tdata[OUT_KIND_LSB +: 2]            <= kind_q;
					m_tdata[OUT_OFF_LSB +: OFFSET_BITS]   <= off_q;
					m_tdata[OUT_BASE_LSB +: REG_BITS]     <=
						(kind_q != MOVE_NONE) ? stack_reg_q : '0;
					m_tdata[OUT_HELD_LSB]                 <= held_q;
					m_tdata[OUT_INUSE_LSB +: INUSE_BITS]  <= inuse_c;
					m_tdata[OUT_PEAK_LSB +: INUSE_BITS]   <= peak_next_c;
					m_tdata[OUT_POOL_LSB]                 <= pool_q;
				end
			end
			default: begin
				mode_q <= mode_q;
			end
		endcase
	end

endmodule

[rtl/tmpra_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmpra_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module tmpra_port_checks (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata
);
	import tmpra_pkg::*;

	logic [1:0] status_c;
	logic [1:0] kind_c;

	assign status_c = m_tdata[OUT_STATUS_LSB +: 2];
	assign kind_c   = m_tdata[OUT_KIND_LSB +: 2];

	// A reset seen at an edge leaves no result pending at the next one.
	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !m_tvalid)
		else $error("result valid after reset");

	// An item is worked on alone: input closes right after a beat is taken.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after a beat was taken");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// Without a move there is no offset and no base register.
	a_no_move: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && kind_c == MOVE_NONE |->
			m_tdata[OUT_OFF_LSB +: OFFSET_BITS] == '0 &&
			m_tdata[OUT_BASE_LSB +: REG_BITS] == '0)
		else $error("offset or base given without a move");

	// A refused request orders no move and leaves nothing held.
	a_error_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && status_c != STATUS_OK |->
			kind_c == MOVE_NONE && !m_tdata[OUT_HELD_LSB])
		else $error("move ordered on an error status");

endmodule

bind temp_register_spill_allocator_core tmpra_port_checks u_tmpra_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

[tb/sv/tmpra_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmpra_checker
// Watches the request, result and configuration ports of the temp register
// allocator, predicts every result beat from its own copy of the slot counts
// and registers, and compares the results in order.
// ----------------------------------------------------------------------------
module tmpra_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // query_reg
	input  logic [1:0]  s_tuser,   // mode
	input  logic        m_tvalid,
	input  logic        m_tready,
	// status, phys_reg, move_kind, stack_offset, base_reg, still_held,
	// temps_in_use, peak_in_use, is_pool_reg, zero fill
	input  logic [63:0] m_tdata,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output int          pending_results,
	output int          fail_count
);
	import tmpra_pkg::*;

	localparam int CNT_MAX = 255;

	typedef struct packed {
		logic [1:0]            status;
		logic [REG_BITS-1:0]   phys;
		logic [1:0]            kind;
		logic [OFFSET_BITS-1:0] offset;
		logic [REG_BITS-1:0]   base;
		logic                  held;
		logic [INUSE_BITS-1:0] inuse;
		logic [INUSE_BITS-1:0] peak;
		logic                  pool;
	} alloc_res_t;

	logic [3:0]            cfg_active;
	logic [63:0]           cfg_map;
	logic                  cfg_spill;
	logic [7:0]            cfg_stack;
	logic [7:0]            slot_use [MAP_SLOTS];
	logic [INUSE_BITS-1:0] peak_use;
	alloc_res_t            alloc_results_q [$];
	int                    errors = 0;
	int                    queued_n;

	assign fail_count      = errors;
	assign pending_results = queued_n;

	function automatic int pool_size();
		if (cfg_active == 4'd0)
			return 1;
		if (cfg_active > MAP_SLOTS)
			return MAP_SLOTS;
		return int'(cfg_active);
	endfunction

	function automatic logic [7:0] slot_phys(input int s);
		return cfg_map[8*s +: 8];
	endfunction

	// Lowest slot whose count is above its upper neighbor, else the last slot.
	function automatic int release_slot(input int n);
		int f;
		f = n - 1;
		for (int i = n - 2; i >= 0; i--)
			if (slot_use[i] > slot_use[i+1])
				f = i;
		return f;
	endfunction

	// Highest slot whose count is below its lower neighbor, else slot 0.
	function automatic int acquire_slot(input int n);
		int a;
		a = 0;
		for (int i = 1; i < n; i++)
			if (slot_use[i] < slot_use[i-1])
				a = i;
		return a;
	endfunction

	function automatic logic [INUSE_BITS-1:0] temps_live(input int n);
		int f;
		int v;
		f = release_slot(n);
		v = (int'(slot_use[f]) - 1) * n + f + 1;
		if (v < 0)
			v = 0;
		if (v > INUSE_MAX)
			v = INUSE_MAX;
		return v[INUSE_BITS-1:0];
	endfunction

	function automatic logic [OFFSET_BITS-1:0] frame_offset(input int s, input int c,
								input int n);
		int v;
		v = ((c - 1) * n + s + c) << WORD_SHIFT;
		return v[OFFSET_BITS-1:0];
	endfunction

	function automatic alloc_res_t predict_allocation(input logic [1:0] op,
							  input logic [7:0] qreg);
		alloc_res_t r;
		int n;
		int s;
		int c;
		logic [INUSE_BITS-1:0] live;
		r = '0;
		n = pool_size();
		case (op)
			MODE_ACQUIRE: begin
				s = acquire_slot(n);
				c = int'(slot_use[s]);
				r.phys = slot_phys(s);
				if (c > 0 && !cfg_spill) begin
					r.status = STATUS_NO_SPILL;
				end else if (c >= CNT_MAX) begin
					r.status = STATUS_OVERFLOW;
				end else begin
					if (c > 0) begin
						r.kind   = MOVE_SPILL;
						r.offset = frame_offset(s, c, n);
					end
					slot_use[s] = 8'(c + 1);
					live = temps_live(n);
					if (live > peak_use)
						peak_use = live;
				end
			end
			MODE_RELEASE: begin
				s = release_slot(n);
				c = int'(slot_use[s]);
				r.phys = slot_phys(s);
				if (c == 0) begin
					r.status = STATUS_UNDERFLOW;
				end else begin
					c--;
					if (c > 0) begin
						r.kind   = MOVE_RELOAD;
						r.offset = frame_offset(s, c, n);
						r.held   = 1'b1;
					end
					slot_use[s] = 8'(c);
				end
			end
			MODE_QUERY: begin
				for (int i = 0; i < n; i++)
					if (slot_phys(i) == qreg)
						r.pool = 1'b1;
			end
			default: begin
				// Idle beat: only the usage figures are reported.
			end
		endcase
		r.base  = (r.kind != MOVE_NONE) ? cfg_stack : '0;
		r.inuse = temps_live(n);
		r.peak  = peak_use;
		return r;
	endfunction

	function automatic string show(input alloc_res_t r);
		return {$sformatf("st=%0d reg=%02h mv=%0d off=%0d base=%02h ",
				  r.status, r.phys, r.kind, r.offset, r.base),
			$sformatf("held=%0b use=%0d peak=%0d pool=%0b",
				  r.held, r.inuse, r.peak, r.pool)};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		alloc_res_t got;
		alloc_res_t want;
		if (!arst_n) begin
			cfg_active = 4'd8;
			cfg_map    = '0;
			cfg_spill  = 1'b1;
			cfg_stack  = '0;
			for (int i = 0; i < MAP_SLOTS; i++)
				slot_use[i] = '0;
			peak_use = '0;
			alloc_results_q.delete();
			queued_n <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_ACTIVE_SLOTS: cfg_active = cfg_data[3:0];
					CFG_REG_MAP:      cfg_map    = cfg_data;
					CFG_SPILL_ENABLE: cfg_spill  = cfg_data[0];
					CFG_STACK_REG:    cfg_stack  = cfg_data[7:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				alloc_results_q.push_back(predict_allocation(s_tuser, s_tdata));
			if (m_tvalid && m_tready) begin
				got.status = m_tdata[OUT_STATUS_LSB +: 2];
				got.phys   = m_tdata[OUT_PHYS_LSB +: REG_BITS];
				got.kind   = m_tdata[OUT_KIND_LSB +: 2];
				got.offset = m_tdata[OUT_OFF_LSB +: OFFSET_BITS];
				got.base   = m_tdata[OUT_BASE_LSB +: REG_BITS];
				got.held   = m_tdata[OUT_HELD_LSB];
				got.inuse  = m_tdata[OUT_INUSE_LSB +: INUSE_BITS];
				got.peak   = m_tdata[OUT_PEAK_LSB +: INUSE_BITS];
				got.pool   = m_tdata[OUT_POOL_LSB];
				if (alloc_results_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: result beat with nothing expected: %s",
							 $realtime, show(got));
				end else begin
					want = alloc_results_q.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10) begin
							$display("%0t: result mismatch", $realtime);
							$display("  expected %s", show(want));
							$display("  actual   %s", show(got));
						end
					end
				end
			end
			queued_n <= alloc_results_q.size();
		end
	end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the temp register allocator with a directed opening and several
// randomized phases under different register settings, with random gaps and
// stalls on both streams and one long result stall; the checker beside the
// block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_top;
	import tmpra_pkg::*;

	localparam logic [1:0] MODE_NOP = 2'd3;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 16;
	localparam int QUIET_LIMIT = 4000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;   // query_reg
	logic [1:0]  s_tuser = '0;   // mode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// status, phys_reg, move_kind, stack_offset, base_reg, still_held,
	// temps_in_use, peak_in_use, is_pool_reg, zero fill
	logic [63:0] m_tdata;
	logic        cfg_wr_en = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;

	int          pending_results;
	int          fail_count;
	logic [63:0] cur_map = '0;
	logic        hold_req = 1'b0;
	int          tx_burst = 0;
	int          rx_burst = 0;
	int          quiet_cycles = 0;

	always #2 clk = ~clk;

	temp_register_spill_allocator_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	tmpra_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.pending_results(pending_results),
		.fail_count     (fail_count)
	);

	// Wait draw: mostly a uniform random wait, with occasional runs of back-to-back beats.
	task automatic pick_wait(inout int burst, output int w);
		if (burst > 0) begin
			burst--;
			w = 0;
		end else if ($urandom_range(0, 15) == 0) begin
			burst = $urandom_range(10, 40);
			w = 0;
		end else begin
			w = $urandom_range(0, 9);
		end
	endtask

	task automatic send_beat(input logic [1:0] op, input logic [7:0] qreg);
		int w;
		pick_wait(tx_burst, w);
		if (w > 0) begin
			s_tvalid <= 1'b0;
			repeat (w) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= qreg;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic end_stream();
		s_tvalid <= 1'b0;
	endtask

	task automatic wait_idle();
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [3:0] act, input logic [63:0] map,
				 input logic spill, input logic [7:0] stk);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_ACTIVE_SLOTS;
		cfg_data  <= {60'd0, act};
		@(posedge clk);
		cfg_index <= CFG_REG_MAP;
		cfg_data  <= map;
		@(posedge clk);
		cfg_index <= CFG_SPILL_ENABLE;
		cfg_data  <= {63'd0, spill};
		@(posedge clk);
		cfg_index <= CFG_STACK_REG;
		cfg_data  <= {56'd0, stk};
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cur_map = map;
	endtask

	// Query numbers are drawn half from the current map so that hits are common.
	task automatic run_random(input int count, input int w_acq, input int w_rel,
				  input int w_qry);
		int r;
		logic [1:0] op;
		logic [7:0] qreg;
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(0, 99);
			if (r < w_acq)
				op = MODE_ACQUIRE;
			else if (r < w_acq + w_rel)
				op = MODE_RELEASE;
			else if (r < w_acq + w_rel + w_qry)
				op = MODE_QUERY;
			else
				op = MODE_NOP;
			if ($urandom_range(0, 1) == 1)
				qreg = cur_map[8*$urandom_range(0, 7) +: 8];
			else
				qreg = 8'($urandom_range(0, 255));
			send_beat(op, qreg);
		end
	endtask

	// Result side: random stalls, plus one long stretch when the top asks for it.
	initial begin
		int w;
		logic hold_done;
		hold_done = 1'b0;
		forever begin
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			pick_wait(rx_burst, w);
			if (w > 0) begin
				m_tready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed opening: extreme register numbers at slot 0 and slot 7.
		configure(4'd8, 64'hFF6C_5B4A_3928_1700, 1'b1, 8'hFF);
		send_beat(MODE_RELEASE, 8'h00);     // release of an empty slot
		send_beat(MODE_QUERY, 8'h00);
		send_beat(MODE_QUERY, 8'hFF);
		send_beat(MODE_QUERY, 8'h80);
		send_beat(MODE_NOP, 8'hFF);
		repeat (10) send_beat(MODE_ACQUIRE, 8'h00); // wraps around and spills
		send_beat(MODE_RELEASE, 8'h00);     // reload of a slot still held
		send_beat(MODE_RELEASE, 8'h00);
		send_beat(MODE_QUERY, 8'h17);
		end_stream();
		wait_idle();

		configure(4'd8, 64'hFF6C_5B4A_3928_1700, 1'b0, 8'h00);
		send_beat(MODE_ACQUIRE, 8'h00);     // held slot with spilling disabled
		send_beat(MODE_RELEASE, 8'h00);
		send_beat(MODE_RELEASE, 8'h00);
		send_beat(MODE_ACQUIRE, 8'h00);
		end_stream();
		wait_idle();

		// Balanced traffic over all eight slots, with one long result stall.
		configure(4'd8, {$urandom, $urandom}, 1'b1, 8'($urandom_range(0, 255)));
		run_random(50, 45, 35, 15);
		hold_req = 1'b1;
		run_random(350, 45, 35, 15);
		end_stream();
		wait_idle();

		// A single slot under heavy acquire traffic runs its count into overflow.
		configure(4'd1, 64'd0, 1'b1, 8'hFF);
		run_random(400, 85, 8, 5);
		end_stream();
		wait_idle();

		// Slot count above the pool size, spilling off.
		configure(4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 8'h00);
		run_random(250, 40, 40, 15);
		end_stream();
		wait_idle();

		// Zero slots acts as one; mostly releases to drain the counts.
		configure(4'd0, {$urandom, $urandom}, 1'b1, 8'($urandom_range(0, 255)));
		run_random(200, 10, 85, 3);
		end_stream();
		wait_idle();

		configure(4'($urandom_range(2, 7)), {$urandom, $urandom},
			  1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
		run_random(300, 40, 40, 15);
		end_stream();
		wait_idle();

		configure(4'd8, {$urandom, $urandom}, 1'b1, 8'($urandom_range(0, 255)));
		run_random(150, 50, 35, 10);
		end_stream();
		wait_idle();

		if (fail_count == 0 && pending_results == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[files.f]
rtl/tmpra_pkg.sv
rtl/tmpra_seq.sv
rtl/temp_register_spill_allocator_core.sv
rtl/tmpra_checker.sv
tb/sv/tmpra_checker.sv
tb/sv/tb_top.sv
